### rtl/fird_pkg.sv
package fird_pkg;

  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_TOP = 16'h8000;
  localparam logic [2:0] CRC_SPAN = 3'd6;
  localparam int unsigned PIXEL_SHIFT = 2;  // four bytes per pixel
  localparam int unsigned REM_W = 32 + PIXEL_SHIFT;

  typedef enum logic [1:0] {
    PH_FRAME = 2'd0,
    PH_IMAGE = 2'd1,
    PH_BODY  = 2'd2,
    PH_DROP  = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    EV_ABSORB    = 3'd0,
    EV_FRAME_OK  = 3'd1,
    EV_FRAME_BAD = 3'd2,
    EV_IMAGE_OK  = 3'd3,
    EV_IMAGE_BAD = 3'd4,
    EV_BODY      = 3'd5,
    EV_TRUNC     = 3'd6,
    EV_IDLE_END  = 3'd7
  } event_t;

  typedef enum logic [1:0] {
    FLD_HEIGHT   = 2'd0,
    FLD_WIDTH    = 2'd1,
    FLD_CHANNELS = 2'd2,
    FLD_OPCODE   = 2'd3
  } field_t;

  typedef struct packed {
    event_t      event_res;
    logic [7:0]  payload_byte;
    logic        last_body_byte;
    logic [31:0] frame_length;
    logic [15:0] image_height;
    logic [15:0] image_width;
    logic [15:0] image_channels;
    logic [15:0] request_opcode;
  } res_t;

  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if ((c & CRC_TOP) != 16'h0000) begin
        c = (c << 1) ^ CRC_POLY;
      end else begin
        c = c << 1;
      end
    end
    return c;
  endfunction

endpackage

### rtl/fird_core.sv
module fird_core (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         acc_i,
  input  logic [7:0]   data_byte_i,
  input  logic         eos_i,
  output fird_pkg::res_t res_o
);
  import fird_pkg::*;

  phase_t            phase_r, phase_nxt;
  logic [2:0]        idx_r, idx_nxt;
  logic [15:0]       crc_r, crc_nxt;
  logic [7:0]        crc_lo_r, crc_lo_nxt;
  logic [31:0]       len_r, len_nxt;
  logic [15:0]       fld_r [4];
  logic [15:0]       fld_nxt [4];
  logic [REM_W-1:0]  rem_r, rem_nxt;
  logic [15:0]       crc_in;
  logic [1:0]        f_sel;
  logic [31:0]       area;

  assign f_sel = idx_r[2:1];
  assign area = 32'(fld_r[FLD_HEIGHT]) * 32'(fld_r[FLD_WIDTH]);
  assign crc_in = (idx_r == 3'd0) ? 16'h0000 : crc_r;

  always_comb begin
    phase_nxt = phase_r;
    idx_nxt = idx_r;
    crc_nxt = crc_r;
    crc_lo_nxt = crc_lo_r;
    len_nxt = len_r;
    fld_nxt = fld_r;
    rem_nxt = rem_r;
    res_o.event_res = EV_ABSORB;
    res_o.payload_byte = 8'h00;
    res_o.last_body_byte = 1'b0;
    if (eos_i) begin
      if (phase_r == PH_BODY || phase_r == PH_IMAGE ||
          (phase_r == PH_FRAME && idx_r != 3'd0)) begin
        res_o.event_res = EV_TRUNC;
      end else begin
        res_o.event_res = EV_IDLE_END;
      end
      phase_nxt = PH_FRAME;
      idx_nxt = 3'd0;
      crc_nxt = 16'h0000;
      rem_nxt = '0;
    end else begin
      case (phase_r)
        PH_FRAME: begin
          crc_nxt = crc_in;
          if (idx_r < CRC_SPAN) begin
            crc_nxt = crc_feed(crc_in, data_byte_i);
          end
          case (idx_r)
            3'd2: len_nxt = {24'h000000, data_byte_i};
            3'd3: len_nxt[15:8] = data_byte_i;
            3'd4: len_nxt[23:16] = data_byte_i;
            3'd5: len_nxt[31:24] = data_byte_i;
            3'd6: crc_lo_nxt = data_byte_i;
            default: ;
          endcase
          if (idx_r == 3'd7) begin
            if (len_r != 32'h0 && {data_byte_i, crc_lo_r} == crc_r) begin
              res_o.event_res = EV_FRAME_OK;
              phase_nxt = PH_IMAGE;
            end else begin
              res_o.event_res = EV_FRAME_BAD;
              phase_nxt = PH_DROP;
            end
            idx_nxt = 3'd0;
          end else begin
            idx_nxt = idx_r + 3'd1;
          end
        end
        PH_IMAGE: begin
          if (idx_r[0]) begin
            fld_nxt[f_sel] = {data_byte_i, fld_r[f_sel][7:0]};
          end else begin
            fld_nxt[f_sel] = {8'h00, data_byte_i};
          end
          if (idx_r == 3'd7) begin
            if (fld_r[FLD_HEIGHT] != 16'h0 && fld_r[FLD_WIDTH] != 16'h0 &&
                fld_r[FLD_CHANNELS] != 16'h0) begin
              res_o.event_res = EV_IMAGE_OK;
              phase_nxt = PH_BODY;
              rem_nxt = {area, {PIXEL_SHIFT{1'b0}}};
            end else begin
              res_o.event_res = EV_IMAGE_BAD;
              phase_nxt = PH_DROP;
            end
            idx_nxt = 3'd0;
          end else begin
            idx_nxt = idx_r + 3'd1;
          end
        end
        PH_BODY: begin
          res_o.event_res = EV_BODY;
          res_o.payload_byte = data_byte_i;
          if (rem_r <= REM_W'(1)) begin
            res_o.last_body_byte = 1'b1;
            phase_nxt = PH_FRAME;
            idx_nxt = 3'd0;
            crc_nxt = 16'h0000;
            rem_nxt = '0;
          end else begin
            rem_nxt = rem_r - REM_W'(1);
          end
        end
        default: res_o.event_res = EV_ABSORB;
      endcase
    end
    res_o.frame_length = len_nxt;
    res_o.image_height = fld_nxt[FLD_HEIGHT];
    res_o.image_width = fld_nxt[FLD_WIDTH];
    res_o.image_channels = fld_nxt[FLD_CHANNELS];
    res_o.request_opcode = fld_nxt[FLD_OPCODE];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_FRAME;
      idx_r <= 3'd0;
      crc_r <= 16'h0000;
      crc_lo_r <= 8'h00;
      len_r <= 32'h0;
      rem_r <= '0;
      for (int k = 0; k < 4; k++) begin
        fld_r[k] <= 16'h0000;
      end
    end else if (acc_i) begin
      phase_r <= phase_nxt;
      idx_r <= idx_nxt;
      crc_r <= crc_nxt;
      crc_lo_r <= crc_lo_nxt;
      len_r <= len_nxt;
      rem_r <= rem_nxt;
      fld_r <= fld_nxt;
    end
  end

`ifndef SYNTHESIS
  // header index only moves inside a header phase
  a_idx_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_BODY || phase_r == PH_DROP) |-> idx_r == 3'd0)
    else $error("header index nonzero outside header phase");
  // end of stream always returns to frame hunt
  a_eos_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (acc_i && eos_i) |=> (phase_r == PH_FRAME && idx_r == 3'd0 && rem_r == '0))
    else $error("end of stream did not reset framing");
  // last body word closes the frame
  a_last_close: assert property (@(posedge clk) disable iff (!rst_n)
    (acc_i && res_o.last_body_byte) |=> (phase_r == PH_FRAME && idx_r == 3'd0))
    else $error("frame not closed after last body word");
  // body phase always has words left to count
  a_body_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_BODY) |-> rem_r != '0)
    else $error("body phase with empty remaining count");
`endif

endmodule

### rtl/fird_obuf.sv
module fird_obuf (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_i,
  input  fird_pkg::res_t push_data_i,
  output logic           space_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output fird_pkg::res_t out_data_o
);
  import fird_pkg::*;

  res_t       head_r, head_nxt;
  res_t       tail_r, tail_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       pop;

  assign out_valid_o = (cnt_r != 2'd0);
  assign space_o = (cnt_r != 2'd2);
  assign out_data_o = head_r;
  assign pop = out_valid_o && out_ready_i;

  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    cnt_nxt = cnt_r;
    case (cnt_r)
      2'd0: begin
        if (push_i) begin
          head_nxt = push_data_i;
          cnt_nxt = 2'd1;
        end
      end
      2'd1: begin
        if (pop && push_i) begin
          head_nxt = push_data_i;
        end else if (pop) begin
          cnt_nxt = 2'd0;
        end else if (push_i) begin
          tail_nxt = push_data_i;
          cnt_nxt = 2'd2;
        end
      end
      2'd2: begin
        if (pop) begin
          head_nxt = tail_r;
          cnt_nxt = 2'd1;
        end
      end
      default: cnt_nxt = 2'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    head_r <= head_nxt;
    tail_r <= tail_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push_i |-> cnt_r != 2'd2)
    else $error("word pushed into full buffer");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("buffer count out of range");
  a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd2 && !pop) |=> (cnt_r == 2'd2 && $stable(head_r) && $stable(tail_r)))
    else $error("full buffer changed without a pop");
`endif

endmodule

### rtl/framed_image_request_deframer.sv
// channel | valid/ready          | payload
// in      | in_valid/in_ready    | in_data_byte, in_end_of_stream
// out     | out_valid/out_ready  | out_event_res .. out_request_opcode
//
// one byte per cycle sustained while out_ready keeps the buffer from filling; each result word
// is registered in a two-entry output buffer
// crc step, header capture and body count update all settle in the cycle the byte is taken
// in_ready drops only while both buffer entries hold untaken words
// synchronous active-low reset: framing state to frame-header hunt, buffer empty
module framed_image_request_deframer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_end_of_stream,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_event_res,
  output logic [7:0]  out_payload_byte,
  output logic        out_last_body_byte,
  output logic [31:0] out_frame_length,
  output logic [15:0] out_image_height,
  output logic [15:0] out_image_width,
  output logic [15:0] out_image_channels,
  output logic [15:0] out_request_opcode
);
  import fird_pkg::*;

  logic acc;
  res_t res;
  res_t out_res;

  assign acc = in_valid && in_ready;

  fird_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .acc_i       (acc),
    .data_byte_i (in_data_byte),
    .eos_i       (in_end_of_stream),
    .res_o       (res)
  );

  fird_obuf u_obuf (
    .clk         (clk),
    .rst_n       (rst_n),
    .push_i      (acc),
    .push_data_i (res),
    .space_o     (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_res)
  );

  assign out_event_res = out_res.event_res;
  assign out_payload_byte = out_res.payload_byte;
  assign out_last_body_byte = out_res.last_body_byte;
  assign out_frame_length = out_res.frame_length;
  assign out_image_height = out_res.image_height;
  assign out_image_width = out_res.image_width;
  assign out_image_channels = out_res.image_channels;
  assign out_request_opcode = out_res.request_opcode;

endmodule
